FILE: hdl/gfa_pkg.sv
// Package for the grid rectangle first-fit allocator.
// Holds grid sizing, field widths, register indexes and the control/status structs.
// No dependencies.
package gfa_pkg;

  // Grid geometry
  localparam int GRID_DIM   = 16;
  localparam int COL_W      = $clog2(GRID_DIM);
  localparam int ROW_W      = $clog2(GRID_DIM + 1);
  localparam int CNT_W      = $clog2(GRID_DIM + 1);
  localparam int CELL_SHIFT = 4;

  // Field widths
  localparam int SIZE_W    = 9;
  localparam int CODE_W    = 8;
  localparam int CELLS_W   = 6;
  localparam int ARITH_W   = CELLS_W + 2;
  localparam int COORD_W   = 8;
  localparam int VRAM_X_W  = 10;
  localparam int WORDS_W   = 7;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_VRAM_BASE_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUT_WORD   = 1'd1;

  // Constants
  localparam logic [VRAM_X_W-1:0] BASE_X_RESET = 10'h1C0;
  localparam logic [CODE_W-1:0]   CODE_MASK    = 8'hFC;
  localparam logic [CODE_W-1:0]   SPRITE_CODE  = 8'h64;
  localparam logic [9:0]          EDGE_LIMIT   = 10'h100;
  localparam logic [WORDS_W-1:0]  WORDS_MAX    = 7'd127;

  // Controller to datapath
  typedef struct packed {
    logic load_in;    // capture request, clear search state
    logic scan_adv;   // step the scan to the next row
    logic latch_hit;  // record anchor found in the current row
    logic claim;      // mark one row of the rectangle as used
    logic load_out;   // load the result register
  } gfa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_fail;   // no anchor row left, or oversize
    logic hit;         // anchor found in the current row
    logic claim_skip;  // zero-area rectangle, nothing to mark
    logic claim_last;  // last row of the claim
  } gfa_sts_t;

endpackage

FILE: hdl/gfa_ctrl.sv
// Controller state machine for the grid rectangle allocator.
// Sequences capture, row scan, claim and result load. Uses gfa_pkg.
module gfa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  gfa_pkg::gfa_sts_t sts,
  output gfa_pkg::gfa_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_CLAIM = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (sts.scan_fail) begin
          state_nxt = ST_DONE;
        end else if (sts.hit) begin
          cmd.latch_hit = 1'b1;
          state_nxt     = sts.claim_skip ? ST_DONE : ST_CLAIM;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      ST_CLAIM: begin
        cmd.claim = 1'b1;
        if (sts.claim_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid: set on load, cleared once the transaction is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/gfa_dp.sv
// Datapath for the grid rectangle allocator: occupancy grid, per-column
// free-run counters, anchor search, claim writes and the result register. Uses gfa_pkg.
module gfa_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  gfa_pkg::gfa_cmd_t                     cmd,
  output gfa_pkg::gfa_sts_t                     sts,
  input  logic [gfa_pkg::SIZE_W-1:0]            in_rect_width,
  input  logic [gfa_pkg::SIZE_W-1:0]            in_rect_height,
  input  logic [gfa_pkg::CODE_W-1:0]            in_prim_code,
  input  logic                                  cfg_we,
  input  logic [gfa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gfa_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  output logic                                  out_status,
  output logic                                  out_is_sprite,
  output logic [gfa_pkg::COORD_W-1:0]           out_tex_u,
  output logic [gfa_pkg::COORD_W-1:0]           out_tex_v,
  output logic [gfa_pkg::COORD_W-1:0]           out_tex_u_right,
  output logic [gfa_pkg::COORD_W-1:0]           out_tex_v_bottom,
  output logic [gfa_pkg::VRAM_X_W-1:0]          out_vram_x,
  output logic [gfa_pkg::COORD_W-1:0]           out_vram_y,
  output logic [gfa_pkg::WORDS_W-1:0]           out_vram_width
);

  localparam int GD  = gfa_pkg::GRID_DIM;
  localparam int AW  = gfa_pkg::ARITH_W;
  localparam int CW  = gfa_pkg::COL_W;
  localparam int SW  = gfa_pkg::SIZE_W + 1;

  // Request registers
  logic [gfa_pkg::SIZE_W-1:0]   w_r, h_r;
  logic [gfa_pkg::CODE_W-1:0]   code_r;
  logic [gfa_pkg::CELLS_W-1:0]  wc_r, hc_r;
  logic [gfa_pkg::CELLS_W-1:0]  wc_nxt, hc_nxt;

  // Search and claim state
  logic [GD-1:0]                occ_r [GD];
  logic [gfa_pkg::CNT_W-1:0]    cnt_r [GD];
  logic [gfa_pkg::CNT_W-1:0]    cnt_nxt [GD];
  logic [gfa_pkg::ROW_W-1:0]    row_r;
  logic                         found_r;
  logic [CW-1:0]                anc_row_r, anc_col_r;
  logic [CW-1:0]                clm_row_r;
  logic [gfa_pkg::ROW_W-1:0]    clm_k_r;
  logic [gfa_pkg::VRAM_X_W-1:0] base_x_r;

  // Search logic
  logic [gfa_pkg::CELLS_W-1:0]  wc_eff, hc_eff;
  logic                         zero_area, oversize, anchor_ok;
  logic [GD-1:0]                span, rd_data, col_free, hit_vec;
  logic [CW-1:0]                rd_addr, hit_col, hit_row;
  logic [AW-1:0]                hit_row_w;

  // Round sizes up to whole cells
  assign wc_nxt = gfa_pkg::CELLS_W'((SW'(in_rect_width) + SW'(15)) >> gfa_pkg::CELL_SHIFT);
  assign hc_nxt = gfa_pkg::CELLS_W'((SW'(in_rect_height) + SW'(15)) >> gfa_pkg::CELL_SHIFT);

  // A zero-area request only needs a free anchor cell
  assign zero_area = (wc_r == '0) || (hc_r == '0);
  assign wc_eff    = zero_area ? gfa_pkg::CELLS_W'(1) : wc_r;
  assign hc_eff    = zero_area ? gfa_pkg::CELLS_W'(1) : hc_r;
  assign oversize  = (AW'(wc_r) > AW'(GD)) || (AW'(hc_r) > AW'(GD));

  // Anchor row for the current scan row must stay below GRID_DIM - height
  assign anchor_ok = (AW'(row_r) + AW'(hc_r) + AW'(1)) <= (AW'(GD - 1) + AW'(hc_eff));

  // Single read port on the grid, scan row or claim row
  assign rd_addr = cmd.claim ? clm_row_r : row_r[CW-1:0];
  assign rd_data = occ_r[rd_addr];

  // Horizontal window of wc_eff cells
  always_comb begin
    for (int i = 0; i < GD; i++) begin
      span[i] = (AW'(i) < AW'(wc_eff));
    end
  end

  // Per-column window test and vertical run counters; the column bound
  // follows the requested width even when only the anchor is checked
  always_comb begin
    for (int c = 0; c < GD; c++) begin
      col_free[c] = ((AW'(c) + AW'(wc_r)) <= AW'(GD)) &&
                    ((rd_data & (span << c)) == '0);
      if (!col_free[c]) begin
        cnt_nxt[c] = '0;
      end else if (cnt_r[c] == gfa_pkg::CNT_W'(GD)) begin
        cnt_nxt[c] = cnt_r[c];
      end else begin
        cnt_nxt[c] = cnt_r[c] + gfa_pkg::CNT_W'(1);
      end
      hit_vec[c] = (AW'(cnt_nxt[c]) >= AW'(hc_eff));
    end
  end

  // Leftmost qualifying column
  always_comb begin
    hit_col = '0;
    for (int c = GD - 1; c >= 0; c--) begin
      if (hit_vec[c]) begin
        hit_col = CW'(c);
      end
    end
  end

  assign hit_row_w = AW'(row_r) + AW'(1) - AW'(hc_eff);
  assign hit_row   = hit_row_w[CW-1:0];

  // Status to controller
  assign sts.scan_fail  = oversize || !anchor_ok;
  assign sts.hit        = |hit_vec;
  assign sts.claim_skip = zero_area;
  assign sts.claim_last = (AW'(clm_k_r) + AW'(1)) == AW'(hc_r);

  // Request capture, scan and claim bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      w_r     <= in_rect_width;
      h_r     <= in_rect_height;
      code_r  <= in_prim_code;
      wc_r    <= wc_nxt;
      hc_r    <= hc_nxt;
      row_r   <= '0;
      found_r <= 1'b0;
      for (int c = 0; c < GD; c++) begin
        cnt_r[c] <= '0;
      end
    end
    if (cmd.scan_adv) begin
      row_r <= row_r + gfa_pkg::ROW_W'(1);
      for (int c = 0; c < GD; c++) begin
        cnt_r[c] <= cnt_nxt[c];
      end
    end
    if (cmd.latch_hit) begin
      found_r   <= 1'b1;
      anc_row_r <= hit_row;
      anc_col_r <= hit_col;
      clm_row_r <= hit_row;
      clm_k_r   <= '0;
    end
    if (cmd.claim) begin
      clm_row_r <= clm_row_r + CW'(1);
      clm_k_r   <= clm_k_r + gfa_pkg::ROW_W'(1);
    end
  end

  // Occupancy grid and base register; palette word has no effect on results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < GD; r++) begin
        occ_r[r] <= '0;
      end
      base_x_r <= gfa_pkg::BASE_X_RESET;
    end else begin
      if (cmd.claim) begin
        occ_r[clm_row_r] <= rd_data | (span << anc_col_r);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          gfa_pkg::CFG_VRAM_BASE_X: base_x_r <= cfg_wdata[gfa_pkg::VRAM_X_W-1:0];
          gfa_pkg::CFG_CLUT_WORD:   ;
          default:                  ;
        endcase
      end
    end
  end

  // Result arithmetic
  logic                          sprite;
  logic [gfa_pkg::COORD_W-1:0]   u_val, v_val;
  logic [9:0]                    right_sum, right_adj;
  logic [9:0]                    bottom_sum;
  logic [gfa_pkg::VRAM_X_W-1:0]  vx_val;
  logic [9:0]                    words;
  logic [gfa_pkg::WORDS_W-1:0]   words_sat;

  assign sprite     = (code_r & gfa_pkg::CODE_MASK) == gfa_pkg::SPRITE_CODE;
  assign u_val      = gfa_pkg::COORD_W'({anc_col_r, 4'b0000});
  assign v_val      = gfa_pkg::COORD_W'({anc_row_r, 4'b0000});
  assign right_sum  = 10'(u_val) + 10'(w_r);
  assign right_adj  = (right_sum >= gfa_pkg::EDGE_LIMIT) ? right_sum - 10'd1 : right_sum;
  assign bottom_sum = 10'(v_val) + 10'(h_r);
  assign vx_val     = gfa_pkg::VRAM_X_W'({anc_col_r, 2'b00}) + base_x_r;
  assign words      = (10'(w_r) + 10'd3) >> 2;
  assign words_sat  = (words > 10'(gfa_pkg::WORDS_MAX)) ? gfa_pkg::WORDS_MAX
                                                        : words[gfa_pkg::WORDS_W-1:0];

  // Result register; a failed search (full grid or oversize) gives status only
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status       <= !found_r;
      out_is_sprite    <= found_r && sprite;
      out_tex_u        <= found_r ? u_val : '0;
      out_tex_v        <= found_r ? v_val : '0;
      out_tex_u_right  <= (found_r && !sprite) ? right_adj[7:0] : '0;
      out_tex_v_bottom <= (found_r && !sprite) ? bottom_sum[7:0] : '0;
      out_vram_x       <= found_r ? vx_val : '0;
      out_vram_y       <= found_r ? v_val : '0;
      out_vram_width   <= found_r ? words_sat : '0;
    end
  end

endmodule

FILE: hdl/grid_rect_first_fit_alloc_top.sv
// From input acceptance, the block scans the grid one grid row per cycle through the column
// run counters, then claims the rectangle one row per cycle (no claim when the scan fails
// or the area is zero), then loads the result register once the output side is free.
// A new transaction is taken only after the result is loaded; the result register frees the input side.
// Reset (rst_n low, synchronous): grid cleared to all free, VRAM base x 0x1C0, no result pending.
// Top level of the grid rectangle allocator; uses gfa_pkg, gfa_ctrl and gfa_dp.
module grid_rect_first_fit_alloc_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [gfa_pkg::SIZE_W-1:0]     in_rect_width,
  input  logic [gfa_pkg::SIZE_W-1:0]     in_rect_height,
  input  logic [gfa_pkg::CODE_W-1:0]     in_prim_code,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_status,
  output logic                           out_is_sprite,
  output logic [gfa_pkg::COORD_W-1:0]    out_tex_u,
  output logic [gfa_pkg::COORD_W-1:0]    out_tex_v,
  output logic [gfa_pkg::COORD_W-1:0]    out_tex_u_right,
  output logic [gfa_pkg::COORD_W-1:0]    out_tex_v_bottom,
  output logic [gfa_pkg::VRAM_X_W-1:0]   out_vram_x,
  output logic [gfa_pkg::COORD_W-1:0]    out_vram_y,
  output logic [gfa_pkg::WORDS_W-1:0]    out_vram_width,
  input  logic                           cfg_we,
  input  logic [gfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gfa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  gfa_pkg::gfa_cmd_t cmd;
  gfa_pkg::gfa_sts_t sts;

  gfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gfa_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_rect_width    (in_rect_width),
    .in_rect_height   (in_rect_height),
    .in_prim_code     (in_prim_code),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_status       (out_status),
    .out_is_sprite    (out_is_sprite),
    .out_tex_u        (out_tex_u),
    .out_tex_v        (out_tex_v),
    .out_tex_u_right  (out_tex_u_right),
    .out_tex_v_bottom (out_tex_v_bottom),
    .out_vram_x       (out_vram_x),
    .out_vram_y       (out_vram_y),
    .out_vram_width   (out_vram_width)
  );

  // Busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input side not busy after accepting a transaction");

  // Failed result (full grid or oversize) carries zero placement fields and no sprite flag
  a_full_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_tex_u == '0 && out_tex_v == '0 &&
      out_vram_x == '0 && out_vram_width == '0 && !out_is_sprite))
    else $error("full result has nonzero fields");

  // Sprite results have no quad edges
  a_sprite_no_edges: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_sprite) |-> (out_tex_u_right == '0 && out_tex_v_bottom == '0))
    else $error("sprite result has quad edges");

  // Placement: VRAM line equals texture v
  a_vram_y_matches_v: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_status) |-> (out_vram_y == out_tex_v))
    else $error("VRAM y differs from texture v");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for grid_rect_first_fit_alloc_top: a queue-fed driver,
// a monitor and a first-fit grid predictor, run over several idle and register settings.
// Depends on gfa_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
  import gfa_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_REPORTS    = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int PHASE_ITEMS    = 150;
  localparam logic [CFG_DATA_W-1:0] CLUT_RESET = 16'h7C3C;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [CODE_W-1:0] code;
  } rect_req_t;

  typedef struct packed {
    logic                status;
    logic                is_sprite;
    logic [COORD_W-1:0]  tex_u;
    logic [COORD_W-1:0]  tex_v;
    logic [COORD_W-1:0]  tex_u_right;
    logic [COORD_W-1:0]  tex_v_bottom;
    logic [VRAM_X_W-1:0] vram_x;
    logic [COORD_W-1:0]  vram_y;
    logic [WORDS_W-1:0]  vram_width;
  } placement_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SIZE_W-1:0]     in_rect_width = '0;
  logic [SIZE_W-1:0]     in_rect_height = '0;
  logic [CODE_W-1:0]     in_prim_code = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_status;
  logic                  out_is_sprite;
  logic [COORD_W-1:0]    out_tex_u;
  logic [COORD_W-1:0]    out_tex_v;
  logic [COORD_W-1:0]    out_tex_u_right;
  logic [COORD_W-1:0]    out_tex_v_bottom;
  logic [VRAM_X_W-1:0]   out_vram_x;
  logic [COORD_W-1:0]    out_vram_y;
  logic [WORDS_W-1:0]    out_vram_width;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state: occupancy grid and register copies
  logic [GRID_DIM-1:0] occ_model [GRID_DIM];
  logic [VRAM_X_W-1:0] base_x_model;
  logic [CFG_DATA_W-1:0] clut_model;

  rect_req_t   req_q[$];
  placement_t  placement_q[$];
  logic        in_taken = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          err_count = 0;
  int          quiet_cycles = 0;

  grid_rect_first_fit_alloc_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rect_width    (in_rect_width),
    .in_rect_height   (in_rect_height),
    .in_prim_code     (in_prim_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_is_sprite    (out_is_sprite),
    .out_tex_u        (out_tex_u),
    .out_tex_v        (out_tex_v),
    .out_tex_u_right  (out_tex_u_right),
    .out_tex_v_bottom (out_tex_v_bottom),
    .out_vram_x       (out_vram_x),
    .out_vram_y       (out_vram_y),
    .out_vram_width   (out_vram_width),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // First-fit search and claim on the grid copy; returns the expected placement
  function automatic placement_t place_rect(input rect_req_t req);
    placement_t res;
    int wc, hc, u, v, right, words;
    logic [63:0] span;
    logic fits, done;
    res = '0;
    res.status = 1'b1;
    done = 1'b0;
    wc = (int'(req.width) + 15) >> CELL_SHIFT;
    hc = (int'(req.height) + 15) >> CELL_SHIFT;
    if (wc > GRID_DIM || hc > GRID_DIM) return res;
    // strict row bound: the bottom-most fitting row is never tried
    for (int row = 0; row < GRID_DIM - hc && !done; row++) begin
      for (int col = 0; col <= GRID_DIM - wc && col < GRID_DIM && !done; col++) begin
        span = (wc == 0) ? 64'd0 : (((64'd1 << wc) - 64'd1) << col);
        fits = !occ_model[row][col];
        for (int r = row; r < row + hc; r++)
          if ((occ_model[r] & span[GRID_DIM-1:0]) != '0) fits = 1'b0;
        if (fits) begin
          for (int r = row; r < row + hc; r++)
            occ_model[r] = occ_model[r] | span[GRID_DIM-1:0];
          u = col << CELL_SHIFT;
          v = row << CELL_SHIFT;
          res.status    = 1'b0;
          res.is_sprite = (req.code & CODE_MASK) == SPRITE_CODE;
          res.tex_u     = COORD_W'(u);
          res.tex_v     = COORD_W'(v);
          if (!res.is_sprite) begin
            right = u + int'(req.width);
            if (right >= int'(EDGE_LIMIT)) right = right - 1;
            res.tex_u_right  = COORD_W'(right);
            res.tex_v_bottom = COORD_W'(v + int'(req.height));
          end
          res.vram_x = VRAM_X_W'(col * 4 + int'(base_x_model));
          res.vram_y = COORD_W'(v);
          words = (int'(req.width) + 3) >> 2;
          res.vram_width = (words > int'(WORDS_MAX)) ? WORDS_MAX : WORDS_W'(words);
          done = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic string fmt_placement(input placement_t p);
    return $sformatf("st=%0d spr=%0d u=%0d v=%0d ur=%0d vb=%0d vx=%0d vy=%0d vw=%0d",
                     p.status, p.is_sprite, p.tex_u, p.tex_v, p.tex_u_right,
                     p.tex_v_bottom, p.vram_x, p.vram_y, p.vram_width);
  endfunction

  // Driver: new transaction or idle at the falling edge, payload held while stalled
  always @(negedge clk) begin : driver
    rect_req_t nxt;
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = req_q.pop_front();
        in_valid       <= 1'b1;
        in_rect_width  <= nxt.width;
        in_rect_height <= nxt.height;
        in_prim_code   <= nxt.code;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check results, predict on accepted inputs, watchdog
  always @(posedge clk) begin : monitor
    placement_t got, want;
    logic in_fire, out_fire;
    if (rst_n) begin
      in_fire  = in_valid && !in_stall;
      out_fire = out_valid && !out_stall;
      if (out_fire) begin
        got = {out_status, out_is_sprite, out_tex_u, out_tex_v, out_tex_u_right,
               out_tex_v_bottom, out_vram_x, out_vram_y, out_vram_width};
        if (placement_q.size() == 0) begin
          if (err_count < MAX_REPORTS)
            $display("%0t: unexpected result: %s", $realtime, fmt_placement(got));
          err_count++;
        end else begin
          want = placement_q.pop_front();
          if (got != want) begin
            if (err_count < MAX_REPORTS) begin
              $display("%0t: mismatch", $realtime);
              $display("  expected %s", fmt_placement(want));
              $display("  actual   %s", fmt_placement(got));
            end
            err_count++;
          end
        end
      end
      if (in_fire)
        placement_q.push_back(place_rect({in_rect_width, in_rect_height, in_prim_code}));
      in_taken <= in_fire;

      if (in_fire || out_fire ||
          (req_q.size() == 0 && !in_valid && placement_q.size() == 0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("grid_rect_first_fit_alloc_top regression: fail");
        $finish;
      end
    end
  end

  task automatic queue_req(input int w, input int h, input int code);
    req_q.push_back({SIZE_W'(w), SIZE_W'(h), CODE_W'(code)});
  endtask

  // Random mix: many zero-area requests keep placements coming once the grid fills
  task automatic queue_random(input int n);
    int pick, w, h, code;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(257, 511) : $urandom_range(0, 256);
        h = 0;
      end else if (pick < 40) begin
        w = 0;
        h = $urandom_range(0, 256);
      end else if (pick < 80) begin
        w = $urandom_range(1, 64);
        h = $urandom_range(1, 48);
      end else if (pick < 92) begin
        w = $urandom_range(1, 256);
        h = $urandom_range(1, 256);
      end else begin
        w = $urandom_range(0, 511);
        h = $urandom_range(0, 511);
      end
      if ($urandom_range(0, 1) == 0)
        code = int'(SPRITE_CODE) | $urandom_range(0, 3);
      else
        code = $urandom_range(0, 255);
      queue_req(w, h, code);
    end
  endtask

  // Wait until every request is sent and every result checked
  task automatic wait_drained();
    @(posedge clk);
    while (req_q.size() != 0 || in_valid || placement_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_VRAM_BASE_X) base_x_model = data[VRAM_X_W-1:0];
    else clut_model = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int base_x, input int clut,
                           input int send_pct, input int recv_pct);
    write_reg(CFG_VRAM_BASE_X, {6'($urandom), VRAM_X_W'(base_x)});
    write_reg(CFG_CLUT_WORD, CFG_DATA_W'(clut));
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random(PHASE_ITEMS);
    wait_drained();
  endtask

  initial begin : stimulus
    for (int r = 0; r < GRID_DIM; r++) occ_model[r] = '0;
    base_x_model = BASE_X_RESET;
    clut_model   = CLUT_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: reset registers, no idling
    queue_req(0, 0, 8'h00);      // zero size, quad
    queue_req(0, 0, 8'h64);      // zero size, sprite
    queue_req(256, 0, 8'h00);    // full width, right edge hits 256
    queue_req(511, 0, 8'hFF);    // oversize wide
    queue_req(0, 511, 8'h67);    // oversize tall
    queue_req(257, 16, 8'h20);   // one cell too wide
    queue_req(16, 256, 8'h00);   // full height: row bound leaves no row
    queue_req(1, 1, 8'h65);
    queue_req(15, 15, 8'h66);
    queue_req(16, 16, 8'h67);
    queue_req(17, 17, 8'h63);    // rounds up to 2 by 2 cells
    queue_req(0, 32, 8'h68);     // zero width, only the anchor must be free
    queue_req(32, 0, 8'hE4);     // upper bits differ from sprite code
    queue_req(240, 240, 8'h00);  // no room at the single allowed row
    queue_req(64, 224, 8'hA5);
    queue_req(100, 32, 8'h64);
    queue_req(3, 5, 8'h00);
    queue_req(255, 0, 8'h7F);
    queue_req(128, 1, 8'hFC);
    queue_req(48, 48, 8'h01);
    queue_random(PHASE_ITEMS);
    wait_drained();

    run_phase(0, 0, 46, 0);
    run_phase(1023, 16'hFFFF, 0, 46);
    run_phase($urandom_range(1, 1022), $urandom_range(1, 16'hFFFE), 24, 24);
    run_phase(1020, 16'h8001, 0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && placement_q.size() == 0)
      $display("grid_rect_first_fit_alloc_top regression: pass");
    else
      $display("grid_rect_first_fit_alloc_top regression: fail");
    $finish;
  end

endmodule
